FILE: hdl/vfa_pkg.sv
// shared types, opcodes, error codes and pipeline depths of the vector alu
// no dependencies
package vfa_pkg;

	localparam int FRAC_BITS_DEF = 16;

	typedef logic signed [31:0] lane_t;

	localparam lane_t LANE_MAX = 32'sh7fffffff;
	localparam lane_t LANE_MIN = 32'sh80000000;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_DIV   = 4'd3,
		OP_MULS  = 4'd4,
		OP_DIVS  = 4'd5,
		OP_CLAMP = 4'd6,
		OP_DOT   = 4'd7,
		OP_LEN   = 4'd8,
		OP_NORM  = 4'd9,
		OP_EQ    = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_DIV0   = 2'd1,
		ERR_BOUNDS = 2'd2
	} err_t;

	// quotient magnitude bits, two per stage
	localparam int QUO_BITS    = 33;
	localparam int DIV_STAGES  = (QUO_BITS + 1) / 2;
	localparam int DIV_LAT     = DIV_STAGES + 1;
	// 32 root digits, two per stage
	localparam int SQRT_STAGES = 16;
	localparam int PIPE_LAT    = 2 + SQRT_STAGES + DIV_LAT + 1;

	typedef struct packed {
		logic [3:0]  op;
		lane_t [3:0] r;
		lane_t       scal;
		logic        eq;
		err_t        err;
		logic        need_div;
		lane_t [3:0] a;
		lane_t [3:0] d;
	} carry_t;

endpackage

FILE: hdl/vfa_div_lane.sv
// pipelined signed fixed point divider for one lane, two quotient bits per stage
// depends on vfa_pkg
module vfa_div_lane import vfa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  en,
	input  lane_t a,
	input  lane_t d,
	output lane_t q
);

	localparam int NW = 32 + FRAC_BITS;

	function automatic logic [NW+QUO_BITS-1:0] div_step(input logic [NW-1:0] rem,
		input logic [QUO_BITS-1:0] quo, input logic [31:0] dm, input logic [5:0] k);
		logic [65:0] sh;
		logic [NW-1:0] r;
		logic [QUO_BITS-1:0] qq;
		sh = {34'b0, dm} << k;
		r = rem;
		qq = quo;
		if ({{(66-NW){1'b0}}, rem} >= sh) begin
			r = rem - sh[NW-1:0];
			qq[k] = 1'b1;
		end
		return {r, qq};
	endfunction

	logic [NW-1:0]       rem_s [0:DIV_STAGES];
	logic [QUO_BITS-1:0] quo_s [0:DIV_STAGES];
	logic [31:0]         dm_s  [0:DIV_STAGES];
	logic                neg_s [0:DIV_STAGES];
	logic                ovf_s [0:DIV_STAGES];

	logic [31:0]   am, dmag;
	logic [NW-1:0] na;

	// magnitudes and early overflow check
	always_comb begin
		am   = a[31] ? (~a + 32'd1) : a;
		dmag = d[31] ? (~d + 32'd1) : d;
		na   = {am, {FRAC_BITS{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= na;
			quo_s[0] <= '0;
			dm_s[0]  <= dmag;
			neg_s[0] <= a[31] ^ d[31];
			ovf_s[0] <= {{(66-NW){1'b0}}, na} >= {1'b0, dmag, 33'b0};
		end
	end

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		localparam int K1 = QUO_BITS - 1 - 2 * s;
		localparam int K2 = K1 - 1;
		logic [NW+QUO_BITS-1:0] st1, st2;
		always_comb begin
			st1 = div_step(rem_s[s], quo_s[s], dm_s[s], 6'(K1));
			st2 = st1;
			if (K2 >= 0) begin
				st2 = div_step(st1[NW+QUO_BITS-1:QUO_BITS], st1[QUO_BITS-1:0], dm_s[s],
					6'(K2 < 0 ? 0 : K2));
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s+1] <= st2[NW+QUO_BITS-1:QUO_BITS];
				quo_s[s+1] <= st2[QUO_BITS-1:0];
				dm_s[s+1]  <= dm_s[s];
				neg_s[s+1] <= neg_s[s];
				ovf_s[s+1] <= ovf_s[s];
			end
		end
	end

	// sign and saturation
	always_comb begin
		if (neg_s[DIV_STAGES]) begin
			if (ovf_s[DIV_STAGES] || quo_s[DIV_STAGES] > 33'h080000000) begin
				q = LANE_MIN;
			end else begin
				q = ~quo_s[DIV_STAGES][31:0] + 32'd1;
			end
		end else begin
			if (ovf_s[DIV_STAGES] || quo_s[DIV_STAGES] > 33'h07fffffff) begin
				q = LANE_MAX;
			end else begin
				q = quo_s[DIV_STAGES][31:0];
			end
		end
	end

endmodule

FILE: hdl/vec4_fixed_point_alu_top.sv
// four-lane fixed point vector alu, fully pipelined
// one request per cycle while no finished result waits untaken at the output
// the pipeline is made of the multiply and lane stages (2), the pipelined root (16 stages),
// the divider (18 stages) and the output register (1)
// the whole pipeline holds while a finished result waits at the output
// reset clears the stage valid bits only; payload registers are not reset
// depends on vfa_pkg and vfa_div_lane
module vec4_fixed_point_alu_top import vfa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  lane_t       a_x,
	input  lane_t       a_y,
	input  lane_t       a_z,
	input  lane_t       a_w,
	input  lane_t       b_x,
	input  lane_t       b_y,
	input  lane_t       b_z,
	input  lane_t       b_w,
	input  lane_t       scalar_in,
	input  lane_t       clamp_low,
	input  lane_t       clamp_high,
	output logic        out_valid,
	input  logic        out_ready,
	output lane_t       r_x,
	output lane_t       r_y,
	output lane_t       r_z,
	output lane_t       r_w,
	output lane_t       scalar_out,
	output logic        is_equal,
	output logic [1:0]  error_code
);

	// saturate a 33-bit sum
	function automatic lane_t sat33(input logic signed [32:0] v);
		if (v > 33'sh07fffffff) return LANE_MAX;
		if (v < -33'sh080000000) return LANE_MIN;
		return v[31:0];
	endfunction

	// saturate a wide signed value
	function automatic lane_t sat66(input logic signed [65:0] v);
		if (v > 66'sh07fffffff) return LANE_MAX;
		if (v < -66'sh080000000) return LANE_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] lane_mul(input lane_t x, input lane_t y);
		logic signed [63:0] ex, ey;
		ex = x;
		ey = y;
		return ex * ey;
	endfunction

	// one digit of the bit-by-bit square root
	function automatic logic [127:0] sq_step(input logic [63:0] n, input logic [63:0] res,
		input logic [4:0] p);
		logic [63:0] bt, nn, rr;
		bt = 64'd1 << {p, 1'b0};
		if (n >= res + bt) begin
			nn = n - (res + bt);
			rr = (res >> 1) + bt;
		end else begin
			nn = n;
			rr = res >> 1;
		end
		return {nn, rr};
	endfunction

	// whole-pipeline advance: hold only when the output is full and not taken
	logic                 en;
	logic [PIPE_LAT-1:0]  valid_s;

	assign en        = !valid_s[PIPE_LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = valid_s[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[PIPE_LAT-2:0], in_valid};
		end
	end

	// stage 1: operand select and the four lane multipliers
	lane_t in_a [4];
	lane_t in_b [4];
	lane_t m2   [4];

	assign in_a = '{a_x, a_y, a_z, a_w};
	assign in_b = '{b_x, b_y, b_z, b_w};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			unique case (opcode)
				OP_MULS:         m2[i] = scalar_in;
				OP_LEN, OP_NORM: m2[i] = in_a[i];
				default:         m2[i] = in_b[i];
			endcase
		end
	end

	logic [3:0]         op_s1;
	lane_t              a_s1 [4];
	lane_t              b_s1 [4];
	lane_t              sc_s1, lo_s1, hi_s1;
	logic signed [63:0] prod_s1 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= opcode;
			sc_s1 <= scalar_in;
			lo_s1 <= clamp_low;
			hi_s1 <= clamp_high;
			for (int i = 0; i < 4; i++) begin
				a_s1[i]    <= in_a[i];
				b_s1[i]    <= in_b[i];
				prod_s1[i] <= lane_mul(in_a[i], m2[i]);
			end
		end
	end

	// stage 2: lane results, dot sum and sum of squares
	carry_t             c2;
	logic [65:0]        qsum;
	logic signed [65:0] dsum;
	logic signed [65:0] mt [4];
	logic               b_zero;

	always_comb begin
		c2          = '0;
		c2.op       = op_s1;
		c2.err      = ERR_NONE;
		dsum        = '0;
		qsum        = '0;
		b_zero      = 1'b0;
		for (int i = 0; i < 4; i++) begin
			c2.a[i] = a_s1[i];
			mt[i]   = prod_s1[i] >>> FRAC_BITS;
			dsum    = dsum + prod_s1[i];
			qsum    = qsum + {2'b0, prod_s1[i]};
			if (b_s1[i] == '0) b_zero = 1'b1;
		end
		dsum = dsum >>> FRAC_BITS;
		unique case (op_s1)
			OP_ADD: begin
				for (int i = 0; i < 4; i++)
					c2.r[i] = sat33({a_s1[i][31], a_s1[i]} + {b_s1[i][31], b_s1[i]});
			end
			OP_SUB: begin
				for (int i = 0; i < 4; i++)
					c2.r[i] = sat33({a_s1[i][31], a_s1[i]} - {b_s1[i][31], b_s1[i]});
			end
			OP_MUL, OP_MULS: begin
				for (int i = 0; i < 4; i++) c2.r[i] = sat66(mt[i]);
			end
			OP_DIV: begin
				if (b_zero) begin
					for (int i = 0; i < 4; i++) c2.r[i] = a_s1[i];
					c2.err = ERR_DIV0;
				end else begin
					c2.need_div = 1'b1;
					for (int i = 0; i < 4; i++) c2.d[i] = b_s1[i];
				end
			end
			OP_DIVS: begin
				if (sc_s1 == '0) begin
					for (int i = 0; i < 4; i++) c2.r[i] = a_s1[i];
					c2.err = ERR_DIV0;
				end else begin
					c2.need_div = 1'b1;
					for (int i = 0; i < 4; i++) c2.d[i] = sc_s1;
				end
			end
			OP_CLAMP: begin
				for (int i = 0; i < 4; i++) c2.r[i] = a_s1[i];
				if (lo_s1 > hi_s1) begin
					c2.err = ERR_BOUNDS;
				end else begin
					for (int i = 0; i < 4; i++) begin
						if (a_s1[i] < lo_s1) c2.r[i] = lo_s1;
						else if (a_s1[i] > hi_s1) c2.r[i] = hi_s1;
					end
				end
			end
			OP_DOT: c2.scal = sat66(dsum);
			OP_EQ: begin
				c2.eq = (a_s1[0] == b_s1[0]) && (a_s1[1] == b_s1[1]) &&
					(a_s1[2] == b_s1[2]) && (a_s1[3] == b_s1[3]);
			end
			default: begin
				// length and normalize finish after the root; unknown codes give zeros
			end
		endcase
	end

	// root pipeline, index 0 is the stage 2 register
	carry_t      cq_s  [0:SQRT_STAGES];
	logic [63:0] sqn_s [0:SQRT_STAGES];
	logic [63:0] sqr_s [0:SQRT_STAGES];
	logic        cap_s [0:SQRT_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			cq_s[0]  <= c2;
			sqn_s[0] <= qsum[63:0];
			sqr_s[0] <= '0;
			// sum of squares at or above 2^62 saturates the length
			cap_s[0] <= qsum >= (66'd1 << 62);
		end
	end

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
		logic [127:0] t1, t2;
		always_comb begin
			t1 = sq_step(sqn_s[j], sqr_s[j], 5'(31 - 2 * j));
			t2 = sq_step(t1[127:64], t1[63:0], 5'(30 - 2 * j));
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cq_s[j+1]  <= cq_s[j];
				sqn_s[j+1] <= t2[127:64];
				sqr_s[j+1] <= t2[63:0];
				cap_s[j+1] <= cap_s[j];
			end
		end
	end

	// length known: finish length, set up normalize divisors
	carry_t cp;
	lane_t  len;

	always_comb begin
		len = cap_s[SQRT_STAGES] ? LANE_MAX : {1'b0, sqr_s[SQRT_STAGES][30:0]};
		cp  = cq_s[SQRT_STAGES];
		if (cp.op == OP_LEN) cp.scal = len;
		if (cp.op == OP_NORM) begin
			if (len == '0) begin
				cp.r   = cp.a;
				cp.err = ERR_DIV0;
			end else begin
				cp.need_div = 1'b1;
				for (int i = 0; i < 4; i++) cp.d[i] = len;
			end
		end
	end

	// four lane dividers
	lane_t quo [4];

	for (genvar i = 0; i < 4; i++) begin : g_div
		vfa_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk (clk),
			.en  (en),
			.a   (cp.a[i]),
			.d   (cp.d[i]),
			.q   (quo[i])
		);
	end

	// carry runs beside the dividers
	carry_t cd_s [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			cd_s[0] <= cp;
			for (int k = 1; k < DIV_LAT; k++) cd_s[k] <= cd_s[k-1];
		end
	end

	// output stage doubles as the skid register toward the consumer
	carry_t cf;
	carry_t out_s37;

	always_comb begin
		cf = cd_s[DIV_LAT-1];
		if (cf.need_div) begin
			for (int i = 0; i < 4; i++) cf.r[i] = quo[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_s37 <= cf;
	end

	assign r_x        = out_s37.r[0];
	assign r_y        = out_s37.r[1];
	assign r_z        = out_s37.r[2];
	assign r_w        = out_s37.r[3];
	assign scalar_out = out_s37.scal;
	assign is_equal   = out_s37.eq;
	assign error_code = out_s37.err;

endmodule

FILE: verif/tb_top.sv
// self-checking testbench of the four-lane fixed point vector alu
// predicts each result from its own fixed point arithmetic; depends on vfa_pkg and the alu rtl
module tb_top;
	import vfa_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LIMIT = 20000;
	localparam int N_RANDOM = 430;

	// one request and one result
	typedef struct packed {
		logic [3:0]  op;
		lane_t [3:0] a;
		lane_t [3:0] b;
		lane_t       sc;
		lane_t       lo;
		lane_t       hi;
	} vreq_t;

	typedef struct packed {
		lane_t [3:0] r;
		lane_t       scal;
		logic        eq;
		logic [1:0]  err;
	} vres_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	vreq_t cur = '0;
	vres_t got;

	vreq_t pending_reqs[$];
	vres_t expected_results[$];
	int mismatches = 0;
	int stall_cycles = 0;
	int send_idle_pct = 13;
	int recv_idle_pct = 59;
	// request taken at the last rising edge
	bit in_acc = 1'b0;

	vec4_fixed_point_alu_top #(.FRAC_BITS(FRAC)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(cur.op),
		.a_x(cur.a[0]), .a_y(cur.a[1]), .a_z(cur.a[2]), .a_w(cur.a[3]),
		.b_x(cur.b[0]), .b_y(cur.b[1]), .b_z(cur.b[2]), .b_w(cur.b[3]),
		.scalar_in(cur.sc), .clamp_low(cur.lo), .clamp_high(cur.hi),
		.out_valid(out_valid), .out_ready(out_ready),
		.r_x(got.r[0]), .r_y(got.r[1]), .r_z(got.r[2]), .r_w(got.r[3]),
		.scalar_out(got.scal), .is_equal(got.eq), .error_code(got.err)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic lane_t sat(input logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return LANE_MAX;
		if (v < -128'sd2147483648)
			return LANE_MIN;
		return v[31:0];
	endfunction

	// arithmetic shift floors, matching the required rounding
	function automatic lane_t fmul(input lane_t x, input lane_t y);
		logic signed [127:0] p;
		p = 128'(x) * 128'(y);
		return sat(p >>> FRAC);
	endfunction

	// signed division truncates toward zero
	function automatic lane_t fdiv(input lane_t x, input lane_t d);
		logic signed [127:0] n;
		n = 128'(x) <<< FRAC;
		return sat(n / 128'(d));
	endfunction

	function automatic lane_t vec_length(input lane_t [3:0] v);
		logic [127:0] s;
		logic [127:0] root;
		s = '0;
		for (int i = 0; i < 4; i++)
			s += 128'($signed(128'(v[i])) * $signed(128'(v[i])));
		if (s >= (128'd1 << 62))
			return LANE_MAX;
		root = '0;
		for (int k = 31; k >= 0; k--)
			if ((root | (128'd1 << k)) * (root | (128'd1 << k)) <= s)
				root |= 128'd1 << k;
		return sat($signed(root));
	endfunction

	function automatic vres_t alu_predict(input vreq_t q);
		vres_t e;
		logic signed [127:0] acc;
		lane_t len;
		e = '0;
		unique case (q.op)
			OP_ADD: for (int i = 0; i < 4; i++) e.r[i] = sat(128'(q.a[i]) + 128'(q.b[i]));
			OP_SUB: for (int i = 0; i < 4; i++) e.r[i] = sat(128'(q.a[i]) - 128'(q.b[i]));
			OP_MUL: for (int i = 0; i < 4; i++) e.r[i] = fmul(q.a[i], q.b[i]);
			OP_DIV: begin
				if (q.b[0] == 0 || q.b[1] == 0 || q.b[2] == 0 || q.b[3] == 0) begin
					e.r = q.a;
					e.err = ERR_DIV0;
				end else
					for (int i = 0; i < 4; i++) e.r[i] = fdiv(q.a[i], q.b[i]);
			end
			OP_MULS: for (int i = 0; i < 4; i++) e.r[i] = fmul(q.a[i], q.sc);
			OP_DIVS: begin
				if (q.sc == 0) begin
					e.r = q.a;
					e.err = ERR_DIV0;
				end else
					for (int i = 0; i < 4; i++) e.r[i] = fdiv(q.a[i], q.sc);
			end
			OP_CLAMP: begin
				e.r = q.a;
				if (q.lo > q.hi)
					e.err = ERR_BOUNDS;
				else
					for (int i = 0; i < 4; i++)
						if (q.a[i] < q.lo) e.r[i] = q.lo;
						else if (q.a[i] > q.hi) e.r[i] = q.hi;
			end
			OP_DOT: begin
				// exact sum then one floor shift
				acc = '0;
				for (int i = 0; i < 4; i++) acc += 128'(q.a[i]) * 128'(q.b[i]);
				e.scal = sat(acc >>> FRAC);
			end
			OP_LEN: e.scal = vec_length(q.a);
			OP_NORM: begin
				len = vec_length(q.a);
				if (len == 0) begin
					e.r = q.a;
					e.err = ERR_DIV0;
				end else
					for (int i = 0; i < 4; i++) e.r[i] = fdiv(q.a[i], len);
			end
			OP_EQ: e.eq = (q.a == q.b);
			default: ;
		endcase
		return e;
	endfunction

	// random lane, biased toward small magnitudes and extremes
	function automatic lane_t rand_lane();
		unique case ($urandom_range(0, 7))
			0: return LANE_MAX;
			1: return LANE_MIN;
			2: return 0;
			3, 4: return $signed(32'($urandom_range(0, 32'h7ffff))) - 32'sh40000;
			default: return $urandom();
		endcase
	endfunction

	function automatic vreq_t rand_req();
		vreq_t q;
		q.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
			: 4'($urandom_range(0, 10));
		for (int i = 0; i < 4; i++) begin
			q.a[i] = rand_lane();
			q.b[i] = ($urandom_range(0, 3) == 0) ? q.a[i] : rand_lane();
		end
		q.sc = rand_lane();
		q.lo = rand_lane();
		q.hi = rand_lane();
		// mostly ordered bounds so clamping is exercised
		if (q.op == OP_CLAMP && q.lo > q.hi && $urandom_range(0, 3) != 0) begin
			q.lo = q.hi;
			q.hi = $signed(q.lo) > 0 ? q.lo : q.lo + 32'sh30000;
		end
		return q;
	endfunction

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_acc) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur <= pending_reqs.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor: sample handshakes on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			in_acc <= in_valid && in_ready;
			if (in_valid && in_ready)
				expected_results.push_back(alu_predict(cur));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", got);
				end else begin
					vres_t e;
					e = expected_results.pop_front();
					if (e !== got) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", e, got);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// watchdog on cycles with no request moving
	always @(posedge clk) begin
		if (stall_cycles >= LIMIT) begin
			$display("** vec4_fixed_point_alu_top: FAILED **");
			$finish;
		end
	end

	task automatic push_req(input logic [3:0] op, input lane_t [3:0] a, input lane_t [3:0] b,
			input lane_t sc, input lane_t lo, input lane_t hi);
		vreq_t q;
		q = '{op: op, a: a, b: b, sc: sc, lo: lo, hi: hi};
		pending_reqs.push_back(q);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		lane_t [3:0] big, one, zero, mixed;
		big = {LANE_MAX, LANE_MIN, LANE_MAX, LANE_MIN};
		one = {4{32'sh10000}};
		zero = '0;
		mixed = {32'sh7fff0000, -32'sh00018000, 32'sh00000001, 32'shffffffff};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, each operation and every special case
		push_req(OP_ADD, big, big, 0, 0, 0);
		push_req(OP_SUB, big, {LANE_MIN, LANE_MAX, LANE_MIN, LANE_MAX}, 0, 0, 0);
		push_req(OP_MUL, big, big, 0, 0, 0);
		push_req(OP_MUL, mixed, {32'sh1, 32'shffffffff, 32'sh8000, 32'sh1}, 0, 0, 0);
		push_req(OP_DIV, big, {32'sh1, 32'shffffffff, 32'sh10000, 32'sh7}, 0, 0, 0);
		push_req(OP_DIV, mixed, {one[3:1], 32'sh0}, 0, 0, 0);
		push_req(OP_MULS, mixed, zero, LANE_MIN, 0, 0);
		push_req(OP_DIVS, mixed, zero, 32'shffff0000, 0, 0);
		push_req(OP_DIVS, mixed, zero, 0, 0, 0);
		push_req(OP_CLAMP, mixed, zero, 0, -32'sh10000, 32'sh10000);
		push_req(OP_CLAMP, mixed, zero, 0, 32'sh10000, -32'sh10000);
		push_req(OP_CLAMP, big, zero, 0, LANE_MIN, LANE_MAX);
		push_req(OP_DOT, big, big, 0, 0, 0);
		push_req(OP_DOT, mixed, mixed, 0, 0, 0);
		push_req(OP_LEN, big, zero, 0, 0, 0);
		push_req(OP_LEN, one, zero, 0, 0, 0);
		push_req(OP_NORM, one, zero, 0, 0, 0);
		push_req(OP_NORM, zero, zero, 0, 0, 0);
		push_req(OP_NORM, {32'sh1, 32'sh0, 32'sh0, 32'sh0}, zero, 0, 0, 0);
		push_req(OP_EQ, mixed, mixed, 0, 0, 0);
		push_req(OP_EQ, mixed, one, 0, 0, 0);
		push_req(4'd15, {4{32'hffffffff}}, {4{32'hffffffff}}, LANE_MIN, LANE_MIN, LANE_MAX);

		// random in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			for (int k = 0; k < N_RANDOM / 3; k++)
				pending_reqs.push_back(rand_req());
			wait_drained();
			if (ph == 0) begin
				send_idle_pct = 59;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		end
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** vec4_fixed_point_alu_top: PASSED **");
		else
			$display("** vec4_fixed_point_alu_top: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
hdl/vfa_pkg.sv
hdl/vfa_div_lane.sv
hdl/vec4_fixed_point_alu_top.sv
verif/tb_top.sv
